/* rtl/sbs_pkg.sv */
package sbs_pkg;

  // default sample width, Q3.(n-4) in and Q5.(n-6) out
  localparam int unsigned SAMPLE_BITS_DEF = 24;

  // width of the per-channel gain shift (0..18)
  localparam int unsigned SHAMT_W = 5;

  // per-channel dither generator seeds
  localparam logic [31:0] LEFT_SEED  = 32'h2545_F491;
  localparam logic [31:0] RIGHT_SEED = 32'h9E37_79B9;

  // dither offset that centers the generator output
  localparam logic [31:0] DITHER_HALF = 32'h7fff_ffff;

  // per-item sequencing strobes from the controller to the channel datapaths
  typedef struct packed {
    logic load;    // input transfer: form the two-tap input sum
    logic shift;   // apply the power-of-two gain, take magnitude
    logic clip;    // clip test and divider setup
    logic div;     // one restoring divide step
    logic commit;  // shape, dither, saturate, update history
  } ctrl_t;

endpackage

/* rtl/sbs_channel.sv */
module sbs_channel #(
  parameter int unsigned SAMPLE_BITS = sbs_pkg::SAMPLE_BITS_DEF,
  parameter logic [31:0] SEED_INIT   = sbs_pkg::LEFT_SEED
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sbs_pkg::ctrl_t                      ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                mute_i,
  input  logic [sbs_pkg::SHAMT_W-1:0]         shamt_i,
  output logic signed [SAMPLE_BITS-1:0]       result_o
);
  import sbs_pkg::*;

  localparam int unsigned SW       = SAMPLE_BITS;
  localparam int unsigned FRAC_X   = SW + 13;
  localparam int unsigned FRAC_OUT = SW - 6;
  localparam int unsigned XW       = SW + 19;      // gained value, signed
  localparam int unsigned CMPW     = XW + 2;       // 5 * |x|
  localparam int unsigned DENW     = FRAC_X + 2;   // divisor 3 - |x|
  localparam int unsigned DW       = DENW + 4;     // divisor aligned to quotient msb
  localparam int unsigned RW       = DW + 1;       // partial remainder

  localparam logic [CMPW-1:0]      ClipLim = CMPW'(14) << FRAC_X;
  localparam logic [DENW-1:0]      ThreeX  = DENW'(3) << FRAC_X;
  localparam logic [SW-1:0]        YClip   = SW'(28) << FRAC_OUT;
  localparam logic signed [SW-1:0] OutMax  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] OutMin  = {1'b1, {(SW-1){1'b0}}};

  logic signed [SW-1:0] prev_in_q;
  logic signed [SW-1:0] prev_sh_q;
  logic [31:0]          seed_q;
  logic signed [SW:0]   sum_in_q;
  logic [XW-1:0]        ax_q;
  logic                 neg_q;
  logic                 clip_q;
  logic [RW-1:0]        rem_q, rem_d;
  logic [DW-1:0]        dk_q;
  logic [SW-1:0]        quo_q;
  logic signed [SW-1:0] result_q;

  // gain shift and magnitude
  logic signed [XW-1:0] x_gain;
  logic [XW-1:0]        ax_d;
  always_comb begin
    x_gain = $signed({{(XW-SW-1){sum_in_q[SW]}}, sum_in_q}) <<< shamt_i;
    ax_d   = x_gain[XW-1] ? XW'(-x_gain) : XW'(x_gain);
    if (mute_i) begin
      ax_d = '0;
    end
  end

  // clip test against 2.8 and divider operands
  logic [CMPW-1:0] ax5;
  logic            clip_d;
  logic [DENW-1:0] den;
  assign ax5    = {ax_q, 2'b00} + CMPW'(ax_q);
  assign clip_d = ax5 > ClipLim;
  assign den    = ThreeX - ax_q[DENW-1:0];

  // restoring divide step, one quotient bit per cycle
  logic          rem_ge;
  logic [RW-1:0] rem_sub;
  logic [RW-1:0] rem_sel;
  always_comb begin
    rem_ge  = rem_q >= {1'b0, dk_q};
    rem_sub = rem_q - {1'b0, dk_q};
    rem_sel = rem_ge ? rem_sub : rem_q;
    rem_d   = {rem_sel[RW-2:0], 1'b0};
  end

  // shaped value with round half up in magnitude
  logic [SW:0]          quo_inc;
  logic [SW-1:0]        y_mag;
  logic signed [SW-1:0] y_sgn;
  logic signed [SW:0]   s2;
  assign quo_inc = {1'b0, quo_q} + (SW+1)'(1);
  assign y_mag   = clip_q ? YClip : quo_inc[SW:1];
  assign y_sgn   = neg_q ? -$signed(y_mag) : $signed(y_mag);
  assign s2      = {y_sgn[SW-1], y_sgn} + {prev_sh_q[SW-1], prev_sh_q};

  // xorshift32 step
  logic [31:0] seed_a, seed_b, seed_n;
  assign seed_a = seed_q ^ (seed_q << 13);
  assign seed_b = seed_a ^ (seed_a >> 17);
  assign seed_n = seed_b ^ (seed_b << 5);

  // dither carry: floor((s2 * 2^31 + seed + 1) / 2^32) = (s2 >>> 1) + carry
  logic               dith_c;
  logic signed [SW:0] rounded;
  logic signed [SW-1:0] sat;
  always_comb begin
    dith_c  = s2[0] ? (seed_n >= DITHER_HALF) : (seed_n == 32'hffff_ffff);
    rounded = {s2[SW], s2[SW:1]} + {{SW{1'b0}}, dith_c};
    sat     = rounded[SW-1:0];
    if (rounded[SW] != rounded[SW-1]) begin
      sat = rounded[SW] ? OutMin : OutMax;
    end
  end

  // channel history and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_in_q <= '0;
      prev_sh_q <= '0;
      seed_q    <= SEED_INIT;
    end else begin
      if (ctrl_i.load) begin
        prev_in_q <= sample_i;
      end
      if (ctrl_i.commit) begin
        prev_sh_q <= y_sgn;
        seed_q    <= seed_n;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sum_in_q <= {sample_i[SW-1], sample_i} + {prev_in_q[SW-1], prev_in_q};
    end
    if (ctrl_i.shift) begin
      ax_q  <= ax_d;
      neg_q <= sum_in_q[SW] & ~mute_i;
    end
    if (ctrl_i.clip) begin
      clip_q <= clip_d;
      if (clip_d) begin
        rem_q <= '0;
        dk_q  <= {ThreeX, 4'b0000};
      end else begin
        rem_q <= RW'({ax_q[DENW-1:0], 1'b0});
        dk_q  <= {den, 4'b0000};
      end
    end
    if (ctrl_i.div) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[SW-2:0], rem_ge};
    end
    if (ctrl_i.commit) begin
      result_q <= sat;
    end
  end

  assign result_o = result_q;

endmodule

/* rtl/stereo_bus_saturator_core.sv */
// channel  direction  handshake                      payload
// in       input      in_valid_i / in_stall_o        left_sample_i, right_sample_i, block_last_i
// out      output     out_valid_o / out_stall_i      left_result_o, right_result_o,
//                                                    block_last_out_o
// cfg      input      cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each item runs from its input transfer through 5 gain divide steps, select, shift, clip,
// SAMPLE_BITS steps of the restoring divider for 2x/(3-x), then the finish state.
// The divider, one quotient bit per cycle in each channel, sets the item time.
// Reset clears history, loads the dither seeds and sets the config registers to their defaults.
// A stalled output holds the finish state; once idle, a new input is taken while the last result waits.
module stereo_bus_saturator_core #(
  parameter int unsigned SAMPLE_BITS = sbs_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  logic                          block_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_result_o,
  output logic signed [SAMPLE_BITS-1:0] right_result_o,
  output logic                          block_last_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import sbs_pkg::*;

  localparam int unsigned CW = $clog2(SAMPLE_BITS);

  localparam logic        RegVolume  = 1'b0;
  localparam logic        RegPan     = 1'b1;
  localparam logic [15:0] CfgReset   = 16'd32768;
  localparam int unsigned GainSteps  = 5;
  localparam logic [24:0] GainNum    = 25'd1310720;
  localparam logic [19:0] GainBase   = 20'd65536;
  localparam logic [21:0] PanNum     = 22'd32768;
  localparam logic [16:0] PanSatLim  = 17'd1024;
  localparam logic [16:0] PanFull    = 17'h10000;
  localparam logic [15:0] PanBoostL  = 16'd40960;
  localparam logic [15:0] PanBoostR  = 16'd24576;
  localparam logic [4:0]  PanMaxPb   = 5'd20;
  localparam logic signed [6:0] ShiftBias = 7'sd3;
  localparam logic signed [6:0] ShiftMin  = -7'sd2;
  localparam logic signed [6:0] ShiftMute = 7'sd17;
  localparam logic signed [6:0] ShiftUnit = 7'sd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_SEL,
    ST_SHIFT,
    ST_CLIP,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q;
  logic            out_valid_q;
  logic            out_last_q;
  logic            last_q;
  logic [15:0]     volume_q;
  logic [15:0]     pan_q;
  logic [24:0]     grem_q;
  logic [21:0]     prem_q;
  logic [4:0]      gquo_q;
  logic [4:0]      pquo_q;
  logic            mute_l_q, mute_r_q;
  logic [SHAMT_W-1:0] shamt_l_q, shamt_r_q;
  ctrl_t           ctrl;

  // configuration writes
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q <= CfgReset;
      pan_q    <= CfgReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegVolume: volume_q <= cfg_data_i;
        RegPan:    pan_q    <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // gain divisors: 10*volume + 1 and distance of pan from the nearer end
  logic [19:0] gdiv;
  logic [16:0] pdiv;
  logic        psat;
  assign gdiv = {1'b0, volume_q, 3'b000} + {3'b000, volume_q, 1'b0} + GainBase;
  assign pdiv = pan_q[15] ? (PanFull - {1'b0, pan_q}) : {1'b0, pan_q};
  assign psat = pdiv <= PanSatLim;

  // restoring divide steps for the gain and pan quotients
  logic        gge, pge;
  logic [24:0] gsel;
  logic [21:0] psel;
  always_comb begin
    gge  = grem_q >= {1'b0, gdiv, 4'b0000};
    gsel = gge ? grem_q - {1'b0, gdiv, 4'b0000} : grem_q;
    pge  = prem_q >= {1'b0, pdiv, 4'b0000};
    psel = pge ? prem_q - {1'b0, pdiv, 4'b0000} : prem_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      grem_q <= GainNum;
      prem_q <= PanNum;
    end else if (state_q == ST_GAIN) begin
      grem_q <= {gsel[23:0], 1'b0};
      prem_q <= {psel[20:0], 1'b0};
      gquo_q <= {gquo_q[3:0], gge};
      pquo_q <= {pquo_q[3:0], pge};
    end
  end

  function automatic logic signed [6:0] clamp_shift(input logic signed [6:0] s);
    logic signed [6:0] r;
    r = s;
    priority if (s < ShiftMin) begin
      r = ShiftMin;
    end else if (s > ShiftMute) begin
      r = ShiftMute;
    end
    return r;
  endfunction

  // per-channel shift from the two quotients
  logic [4:0]        pboost;
  logic signed [6:0] sbase, sl, sr, dl, dr;
  always_comb begin
    pboost = (psat || pquo_q > PanMaxPb) ? PanMaxPb : pquo_q;
    sbase  = $signed({2'b00, gquo_q}) - ShiftBias;
    sl     = sbase + ((pan_q > PanBoostL) ? $signed({2'b00, pboost}) : 7'sd0);
    sr     = sbase + ((pan_q < PanBoostR) ? $signed({2'b00, pboost}) : 7'sd0);
    sl     = clamp_shift(sl);
    sr     = clamp_shift(sr);
    dl     = ShiftUnit - sl;
    dr     = ShiftUnit - sr;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SEL) begin
      mute_l_q  <= sl == ShiftMute;
      mute_r_q  <= sr == ShiftMute;
      shamt_l_q <= (sl == ShiftMute) ? '0 : dl[SHAMT_W-1:0];
      shamt_r_q <= (sr == ShiftMute) ? '0 : dr[SHAMT_W-1:0];
    end
  end

  // sequencing strobes
  always_comb begin
    ctrl.load   = in_valid_i && (state_q == ST_IDLE);
    ctrl.shift  = state_q == ST_SHIFT;
    ctrl.clip   = state_q == ST_CLIP;
    ctrl.div    = state_q == ST_DIV;
    ctrl.commit = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);
  end

  // item sequencer and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !ctrl.commit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (ctrl.load) begin
            last_q  <= block_last_i;
            cnt_q   <= CW'(GainSteps - 1);
            state_q <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            state_q <= ST_SEL;
          end
        end
        ST_SEL:   state_q <= ST_SHIFT;
        ST_SHIFT: state_q <= ST_CLIP;
        ST_CLIP: begin
          cnt_q   <= CW'(SAMPLE_BITS - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (ctrl.commit) begin
            out_valid_q <= 1'b1;
            out_last_q  <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign block_last_out_o = out_last_q;

  sbs_channel #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SEED_INIT   (LEFT_SEED)
  ) u_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (left_sample_i),
    .mute_i   (mute_l_q),
    .shamt_i  (shamt_l_q),
    .result_o (left_result_o)
  );

  sbs_channel #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SEED_INIT   (RIGHT_SEED)
  ) u_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (right_sample_i),
    .mute_i   (mute_r_q),
    .shamt_i  (shamt_r_q),
    .result_o (right_result_o)
  );

  // a new result appears only out of the finish cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result appeared outside finish");

  // the divider moves to finish after its last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == '0) |=> state_q == ST_FIN)
    else $error("divider step count overrun");

  // an input transfer blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while busy");

endmodule
